/* src/zx0_stream_decompressor_assert.svh */
// assertion macros for the zx0 stream decompressor checker
`ifndef ZX0_STREAM_DECOMPRESSOR_ASSERT_SVH
`define ZX0_STREAM_DECOMPRESSOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ZX0_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ZX0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/zx0_pkg.sv */
// ----------------------------------------------------------------------------
// zx0 package
// shared types, phase codes and status codes of the zx0 stream decompressor
// ----------------------------------------------------------------------------
package zx0_pkg;

  localparam int WINDOW_BYTES_DEF = 32768;
  localparam int GAMMA_BITS_DEF   = 32;

  // decoder phase codes
  typedef enum logic [3:0] {
    PH_LIT_LEN    = 4'd0,
    PH_LIT_COPY   = 4'd1,
    PH_AFTER_LIT  = 4'd2,
    PH_REP_LEN    = 4'd3,
    PH_OFS_MSB    = 4'd4,
    PH_OFS_LSB    = 4'd5,
    PH_NEW_LEN    = 4'd6,
    PH_COPY       = 4'd7,
    PH_AFTER_COPY = 4'd8,
    PH_DONE       = 4'd9,
    PH_ERR_OFS    = 4'd10,
    PH_ERR_GAMMA  = 4'd11
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_BAD_OFS   = 2'd2,
    ST_GAMMA_OVF = 2'd3
  } status_t;

  // opcode of an input item
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one result item
  typedef struct packed {
    status_t    status;
    logic       finished;
    logic       wants_byte;
    logic       out_valid;
    logic [7:0] out_byte;
  } result_t;

endpackage

/* src/zx0_stream_decompressor.sv */
// ----------------------------------------------------------------------------
// zx0 stream decompressor
// standard-mode zx0 decoder with a history window in one synchronous ram
// ----------------------------------------------------------------------------
// Each input item (a compressed byte or an advance tick) yields exactly one
// result item with at most one decoded byte and the decoder flags. The core
// runs one decoder step per cycle: a literal goes straight to the done state,
// a match byte takes a run step and a read state for the registered history
// ram read, and an item that walks a gamma code takes one run step per bit
// consumed, one more for a phase change after a literal run and the match
// steps when it ends in a match byte. The next item is taken once the core is idle
// and the output register is empty or hands its result over in the same cycle.
// There is no clearing pass; history is only read where already written.
module zx0_stream_decompressor #(
  parameter int WINDOW_BYTES = zx0_pkg::WINDOW_BYTES_DEF,
  parameter int GAMMA_BITS   = zx0_pkg::GAMMA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic [4:0]  m_axis_tuser   // out_valid, wants_byte, finished, status[1:0]
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic             start, busy, done;
  zx0_pkg::result_t result;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  logic             ov_r;
  zx0_pkg::result_t out_r;

  // take an item when the core is free and the output slot will drain
  assign s_axis_tready = !busy && (!ov_r || m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;

  zx0_core #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .GAMMA_BITS  (GAMMA_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opcode     (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .mem_wr_en  (wr_en),
    .mem_wr_addr(wr_addr),
    .mem_wr_data(wr_data),
    .mem_rd_addr(rd_addr),
    .mem_rd_data(rd_data)
  );

  zx0_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_hist (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register; the slot is free again before the core finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done) begin
      ov_r <= 1'b1;
    end else if (m_axis_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= result;
    end
  end

  assign m_axis_tvalid = ov_r;
  assign m_axis_tdata  = out_r.out_byte;
  assign m_axis_tuser  = {out_r.status, out_r.finished, out_r.wants_byte, out_r.out_valid};

endmodule

/* src/zx0_ram.sv */
// ----------------------------------------------------------------------------
// zx0 ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module zx0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/zx0_core.sv */
// ----------------------------------------------------------------------------
// zx0 core
// decoder sequencer: bit buffer, gamma decoding, phase control and history
// reads and writes for literal and match bytes
// ----------------------------------------------------------------------------
module zx0_core #(
  parameter int WINDOW_BYTES = zx0_pkg::WINDOW_BYTES_DEF,
  parameter int GAMMA_BITS   = zx0_pkg::GAMMA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            opcode,
  input  logic [7:0]                      in_byte,
  output logic                            busy,
  output logic                            done,
  output zx0_pkg::result_t                result,
  output logic                            mem_wr_en,
  output logic [$clog2(WINDOW_BYTES)-1:0] mem_wr_addr,
  output logic [7:0]                      mem_wr_data,
  output logic [$clog2(WINDOW_BYTES)-1:0] mem_rd_addr,
  input  logic [7:0]                      mem_rd_data
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(WINDOW_BYTES + 1);
  localparam logic [CW-1:0] WIN = CW'(WINDOW_BYTES);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } seq_t;

  seq_t                  seq_r, seq_nxt;
  zx0_pkg::phase_t       phase_r, phase_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [CW-1:0]         bw_r, bw_nxt;
  logic [7:0]            buf_r, buf_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic                  reuse_r, reuse_nxt;
  logic                  saved_r, saved_nxt;
  logic [GAMMA_BITS-1:0] gam_r, gam_nxt;
  logic                  pend_r, pend_nxt;
  logic [32:0]           run_r, run_nxt;
  logic [CW-1:0]         mofs_r, mofs_nxt;
  zx0_pkg::result_t      res_r, res_nxt;

  logic                  bit_phase, wants, tb;
  logic [GAMMA_BITS+7:0] ofs_full;
  logic [AW:0]           idx_sum;
  logic [7:0]            wr_byte;
  logic                  wr_en;

  // wants-a-byte condition on current state
  always_comb begin
    bit_phase = (phase_r == zx0_pkg::PH_LIT_LEN) || (phase_r == zx0_pkg::PH_AFTER_LIT) ||
                (phase_r == zx0_pkg::PH_REP_LEN) || (phase_r == zx0_pkg::PH_OFS_MSB) ||
                (phase_r == zx0_pkg::PH_NEW_LEN) || (phase_r == zx0_pkg::PH_AFTER_COPY);
    if (phase_r == zx0_pkg::PH_LIT_COPY) begin
      wants = (run_r != '0);
    end else if (phase_r == zx0_pkg::PH_OFS_LSB) begin
      wants = 1'b1;
    end else begin
      wants = bit_phase && !reuse_r && (pos_r == 4'd0);
    end
    tb = reuse_r ? saved_r : buf_r[3'(pos_r - 4'd1)];
  end

  // new offset from gamma high part and the low byte
  assign ofs_full = {1'b0, gam_r, 7'd0} - {{GAMMA_BITS{1'b0}}, 1'b0, in_byte[7:1]};
  // history read index for the match copy
  assign idx_sum = {1'b0, wp_r} + (AW+1)'(WINDOW_BYTES) - (AW+1)'(mofs_r);
  assign mem_rd_addr = (idx_sum >= (AW+1)'(WINDOW_BYTES)) ?
                       AW'(idx_sum - (AW+1)'(WINDOW_BYTES)) : AW'(idx_sum);

  assign mem_wr_en   = wr_en;
  assign mem_wr_addr = wp_r;
  assign mem_wr_data = wr_byte;

  // one step of the decoder per cycle
  always_comb begin
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    wp_nxt    = wp_r;
    bw_nxt    = bw_r;
    buf_nxt   = buf_r;
    pos_nxt   = pos_r;
    reuse_nxt = reuse_r;
    saved_nxt = saved_r;
    gam_nxt   = gam_r;
    pend_nxt  = pend_r;
    run_nxt   = run_r;
    mofs_nxt  = mofs_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_byte   = in_byte;
    unique case (seq_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          if (phase_r == zx0_pkg::PH_ERR_OFS || phase_r == zx0_pkg::PH_ERR_GAMMA) begin
            seq_nxt = S_DONE;
          end else if (opcode == zx0_pkg::OP_TICK) begin
            seq_nxt = S_RUN;
          end else if (!wants) begin
            res_nxt.status = zx0_pkg::ST_REJECTED;
            seq_nxt = S_DONE;
          end else if (phase_r == zx0_pkg::PH_LIT_COPY) begin
            wr_en = 1'b1;
            wp_nxt = (wp_r == AW'(WINDOW_BYTES - 1)) ? '0 : wp_r + AW'(1);
            if (bw_r < WIN) bw_nxt = bw_r + CW'(1);
            res_nxt.out_byte = in_byte;
            res_nxt.out_valid = 1'b1;
            run_nxt = run_r - 33'd1;
            if (run_r == 33'd1) phase_nxt = zx0_pkg::PH_AFTER_LIT;
            seq_nxt = S_DONE;
          end else if (phase_r == zx0_pkg::PH_OFS_LSB) begin
            gam_nxt = GAMMA_BITS'(1);
            if (ofs_full > (GAMMA_BITS+8)'(bw_r) ||
                ofs_full > (GAMMA_BITS+8)'(WINDOW_BYTES)) begin
              phase_nxt = zx0_pkg::PH_ERR_OFS;
              seq_nxt = S_DONE;
            end else begin
              mofs_nxt  = CW'(ofs_full);
              saved_nxt = in_byte[0];
              reuse_nxt = 1'b1;
              phase_nxt = zx0_pkg::PH_NEW_LEN;
              seq_nxt = S_RUN;
            end
          end else begin
            buf_nxt = in_byte;
            pos_nxt = 4'd8;
            seq_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (phase_r == zx0_pkg::PH_DONE || phase_r == zx0_pkg::PH_ERR_OFS ||
            phase_r == zx0_pkg::PH_ERR_GAMMA || wants) begin
          seq_nxt = S_DONE;
        end else if (phase_r == zx0_pkg::PH_LIT_COPY) begin
          phase_nxt = zx0_pkg::PH_AFTER_LIT;
        end else if (phase_r == zx0_pkg::PH_COPY) begin
          if (mofs_r > bw_r || mofs_r == '0 || mofs_r > WIN) begin
            phase_nxt = zx0_pkg::PH_ERR_OFS;
            seq_nxt = S_DONE;
          end else begin
            seq_nxt = S_READ;
          end
        end else begin
          // consume one bit
          if (reuse_r) reuse_nxt = 1'b0;
          else pos_nxt = pos_r - 4'd1;
          if (phase_r == zx0_pkg::PH_AFTER_LIT) begin
            phase_nxt = tb ? zx0_pkg::PH_OFS_MSB : zx0_pkg::PH_REP_LEN;
          end else if (phase_r == zx0_pkg::PH_AFTER_COPY) begin
            phase_nxt = tb ? zx0_pkg::PH_OFS_MSB : zx0_pkg::PH_LIT_LEN;
          end else if (!pend_r) begin
            if (!tb) begin
              pend_nxt = 1'b1;
            end else if (phase_r == zx0_pkg::PH_OFS_MSB) begin
              phase_nxt = (gam_r == GAMMA_BITS'(256)) ? zx0_pkg::PH_DONE :
                          zx0_pkg::PH_OFS_LSB;
            end else begin
              gam_nxt = GAMMA_BITS'(1);
              if (phase_r == zx0_pkg::PH_LIT_LEN) begin
                run_nxt = 33'(gam_r);
                phase_nxt = zx0_pkg::PH_LIT_COPY;
              end else if (phase_r == zx0_pkg::PH_REP_LEN) begin
                run_nxt = 33'(gam_r);
                phase_nxt = zx0_pkg::PH_COPY;
              end else if (33'(gam_r) == 33'hFFFFFFFF) begin
                phase_nxt = zx0_pkg::PH_ERR_GAMMA;
              end else begin
                run_nxt = 33'(gam_r) + 33'd1;
                phase_nxt = zx0_pkg::PH_COPY;
              end
            end
          end else begin
            pend_nxt = 1'b0;
            if (gam_r[GAMMA_BITS-1]) begin
              phase_nxt = zx0_pkg::PH_ERR_GAMMA;
              seq_nxt = S_DONE;
            end else begin
              gam_nxt = {gam_r[GAMMA_BITS-2:0],
                         tb ^ (phase_r == zx0_pkg::PH_OFS_MSB)};
            end
          end
        end
      end
      S_READ: begin
        // history byte arrives from the registered ram read in the cycle after the address
        wr_en = 1'b1;
        wr_byte = mem_rd_data;
        wp_nxt = (wp_r == AW'(WINDOW_BYTES - 1)) ? '0 : wp_r + AW'(1);
        if (bw_r < WIN) bw_nxt = bw_r + CW'(1);
        res_nxt.out_byte = mem_rd_data;
        res_nxt.out_valid = 1'b1;
        run_nxt = run_r - 33'd1;
        if (run_r == 33'd1) phase_nxt = zx0_pkg::PH_AFTER_COPY;
        seq_nxt = S_DONE;
      end
      S_DONE: begin
        seq_nxt = S_IDLE;
      end
      default: begin
        seq_nxt = S_IDLE;
      end
    endcase
  end

  // result flags follow the state after the step
  always_comb begin
    result = res_r;
    result.wants_byte = wants;
    result.finished = (phase_r == zx0_pkg::PH_DONE);
    if (phase_r == zx0_pkg::PH_ERR_OFS) result.status = zx0_pkg::ST_BAD_OFS;
    else if (phase_r == zx0_pkg::PH_ERR_GAMMA) result.status = zx0_pkg::ST_GAMMA_OVF;
  end

  assign busy = (seq_r != S_IDLE);
  assign done = (seq_r == S_DONE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= S_IDLE;
      phase_r <= zx0_pkg::PH_LIT_LEN;
      wp_r    <= '0;
      bw_r    <= '0;
      buf_r   <= '0;
      pos_r   <= '0;
      reuse_r <= 1'b0;
      saved_r <= 1'b0;
      gam_r   <= GAMMA_BITS'(1);
      pend_r  <= 1'b0;
      run_r   <= '0;
      mofs_r  <= CW'(1);
    end else begin
      seq_r   <= seq_nxt;
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      bw_r    <= bw_nxt;
      buf_r   <= buf_nxt;
      pos_r   <= pos_nxt;
      reuse_r <= reuse_nxt;
      saved_r <= saved_nxt;
      gam_r   <= gam_nxt;
      pend_r  <= pend_nxt;
      run_r   <= run_nxt;
      mofs_r  <= mofs_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* src/zx0_checker.sv */
// ----------------------------------------------------------------------------
// zx0 checker
// port-level checks on the decompressor's result stream
// ----------------------------------------------------------------------------
`include "zx0_stream_decompressor_assert.svh"

module zx0_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [4:0] m_axis_tuser
);

  // a result that stalls keeps its payload
  `ZX0_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  // no decoded byte on a rejected or halted item
  `ZX0_ASSERT_IMP(a_nobyte, clk, rst_n, m_axis_tvalid && m_axis_tuser[4:3] != 2'd0, !m_axis_tuser[0], "byte with error status")
  // with the output slot idle, an accepted item never yields a result next cycle
  `ZX0_ASSERT_NEXT(a_lat, clk, rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result too early")
  // finished and halted never coexist
  `ZX0_ASSERT_IMP(a_fin, clk, rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[4:3] != 2'd2 && m_axis_tuser[4:3] != 2'd3, "finished with halt status")

endmodule

bind zx0_stream_decompressor zx0_checker u_zx0_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
